// ===== rtl/core/hrp_pkg.sv =====
`default_nettype none

package hrp_pkg;

   localparam int unsigned FIELD_WIDTH            = 16;
   localparam int unsigned POSITION_WIDTH_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT    = 4;

   localparam logic [FIELD_WIDTH-1:0] LINE_MAX = '1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   typedef enum logic [3:0] {
      PH_METHOD  = 4'd0,
      PH_URI     = 4'd1,
      PH_PROTO   = 4'd2,
      PH_EOL1    = 4'd3,
      PH_NAME    = 4'd4,
      PH_COLON   = 4'd5,
      PH_VALUE   = 4'd6,
      PH_EOL2    = 4'd7,
      PH_PAYLOAD = 4'd8,
      PH_PENDING = 4'd9,
      PH_HALT    = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      LX_BETWEEN,
      LX_BARE,
      LX_QUOTED,
      LX_AFTER_CR
   } lexer_type;

   typedef enum logic [2:0] {
      KIND_METHOD   = 3'd0,
      KIND_URI      = 3'd1,
      KIND_PROTOCOL = 3'd2,
      KIND_NAME     = 3'd3,
      KIND_VALUE    = 3'd4,
      KIND_PAYLOAD  = 3'd5,
      KIND_END      = 3'd6,
      KIND_ERROR    = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE     = 4'd0,
      ERR_METHOD   = 4'd1,
      ERR_URI      = 4'd2,
      ERR_PROTOCOL = 4'd3,
      ERR_EOL      = 4'd4,
      ERR_NAME     = 4'd5,
      ERR_COLON    = 4'd6,
      ERR_VALUE    = 4'd7,
      ERR_OVERSIZE = 4'd8
   } error_type;

   typedef struct packed {
      kind_type               kind;
      logic [FIELD_WIDTH-1:0] offset;
      logic [FIELD_WIDTH-1:0] length;
      logic [FIELD_WIDTH-1:0] line;
      error_type              code;
      logic                   run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type word0;
      result_type word1;
   } front_out_type;

   function automatic error_type expect_error(phase_type phase);
      error_type code;
      case (phase)
         PH_METHOD: code = ERR_METHOD;
         PH_URI:    code = ERR_URI;
         PH_PROTO:  code = ERR_PROTOCOL;
         PH_EOL1:   code = ERR_EOL;
         PH_NAME:   code = ERR_NAME;
         PH_COLON:  code = ERR_COLON;
         PH_VALUE:  code = ERR_VALUE;
         default:   code = ERR_EOL;
      endcase
      return code;
   endfunction

   function automatic result_type make_word(kind_type kind, logic [FIELD_WIDTH-1:0] offset,
                                            logic [FIELD_WIDTH-1:0] length,
                                            logic [FIELD_WIDTH-1:0] line, error_type code);
      result_type w;
      w.kind     = kind;
      w.offset   = offset;
      w.length   = length;
      w.line     = line;
      w.code     = code;
      w.run_last = 1'b0;
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrp_front.sv =====
`default_nettype none

module hrp_front #(
   parameter int unsigned POSITION_WIDTH = hrp_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  final_byte,
   output hrp_pkg::front_out_type     words
);
   import hrp_pkg::*;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   phase_type                 phase_ff, phase_in;
   lexer_type                 mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] token_start_ff, token_start_in;
   logic [POSITION_WIDTH-1:0] byte_pos_ff, byte_pos_in;
   logic [POSITION_WIDTH-1:0] payload_start_ff, payload_start_in;
   logic [FIELD_WIDTH-1:0]    line_ff, line_in;

   logic [POSITION_WIDTH-1:0] cur, nxt;
   logic [FIELD_WIDTH-1:0]    cur_field;
   logic                      is_delim;
   logic                      close_token, run_between;
   result_type                slot_a, slot_b, slot_c, slot_d;
   logic                      va, vb, vc, vd;
   logic [2:0]                total_valid;

   assign cur       = byte_pos_ff;
   assign nxt       = byte_pos_ff + POSITION_WIDTH'(1);
   assign cur_field = FIELD_WIDTH'(cur);
   assign is_delim  = (data_byte == CHAR_SPACE) || (data_byte == CHAR_CR) ||
                      (data_byte == CHAR_LF) || (data_byte == CHAR_COLON);

   always_comb begin
      phase_in         = (phase_ff > PH_HALT) ? PH_HALT : phase_ff;
      mode_in          = mode_ff;
      token_start_in   = token_start_ff;
      byte_pos_in      = byte_pos_ff;
      payload_start_in = payload_start_ff;
      line_in          = line_ff;
      slot_a = '0; slot_b = '0; slot_c = '0; slot_d = '0;
      va = 1'b0; vb = 1'b0; vc = 1'b0; vd = 1'b0;
      close_token = 1'b0;
      run_between = 1'b0;

      if (phase_in == PH_HALT) begin
      end else if (byte_pos_ff == POS_MAX) begin
         slot_a   = make_word(KIND_ERROR, cur_field, '0, line_in, ERR_OVERSIZE);
         va       = 1'b1;
         phase_in = PH_HALT;
      end else if (phase_in == PH_PAYLOAD) begin
      end else if (phase_in == PH_PENDING) begin
         payload_start_in = (data_byte == CHAR_LF) ? nxt : cur;
         slot_a   = make_word(KIND_PAYLOAD, FIELD_WIDTH'(payload_start_in), '0, line_in,
                              ERR_NONE);
         va       = 1'b1;
         phase_in = PH_PAYLOAD;
         mode_in  = LX_BETWEEN;
      end else begin
         case (mode_ff)
            LX_AFTER_CR: begin
               mode_in     = LX_BETWEEN;
               run_between = (data_byte != CHAR_LF);
            end
            LX_QUOTED: begin
               if (data_byte == CHAR_QUOTE) begin
                  mode_in     = LX_BETWEEN;
                  close_token = 1'b1;
               end
            end
            LX_BARE: begin
               if (is_delim) begin
                  mode_in     = LX_BETWEEN;
                  close_token = 1'b1;
                  run_between = 1'b1;
               end
            end
            default: begin
               run_between = 1'b1;
            end
         endcase

         if (close_token) begin
            va = 1'b1;
            case (phase_in)
               PH_METHOD: begin
                  slot_a   = make_word(KIND_METHOD, FIELD_WIDTH'(token_start_ff),
                                       FIELD_WIDTH'(cur - token_start_ff), line_in, ERR_NONE);
                  phase_in = PH_URI;
               end
               PH_URI: begin
                  slot_a   = make_word(KIND_URI, FIELD_WIDTH'(token_start_ff),
                                       FIELD_WIDTH'(cur - token_start_ff), line_in, ERR_NONE);
                  phase_in = PH_PROTO;
               end
               PH_PROTO: begin
                  slot_a   = make_word(KIND_PROTOCOL, FIELD_WIDTH'(token_start_ff),
                                       FIELD_WIDTH'(cur - token_start_ff), line_in, ERR_NONE);
                  phase_in = PH_EOL1;
               end
               PH_NAME: begin
                  slot_a   = make_word(KIND_NAME, FIELD_WIDTH'(token_start_ff),
                                       FIELD_WIDTH'(cur - token_start_ff), line_in, ERR_NONE);
                  phase_in = PH_COLON;
               end
               PH_VALUE: begin
                  slot_a   = make_word(KIND_VALUE, FIELD_WIDTH'(token_start_ff),
                                       FIELD_WIDTH'(cur - token_start_ff), line_in, ERR_NONE);
                  phase_in = PH_EOL2;
               end
               default: begin
                  slot_a      = make_word(KIND_ERROR, cur_field, '0, line_in,
                                          expect_error(phase_in));
                  phase_in    = PH_HALT;
                  run_between = 1'b0;
               end
            endcase
         end

         if (run_between) begin
            case (data_byte)
               CHAR_SPACE: begin
               end
               CHAR_CR, CHAR_LF: begin
                  if (data_byte == CHAR_CR) begin
                     mode_in = LX_AFTER_CR;
                  end
                  if ((phase_in == PH_EOL1) || (phase_in == PH_EOL2)) begin
                     if (line_in != LINE_MAX) begin
                        line_in = line_in + FIELD_WIDTH'(1);
                     end
                     phase_in = PH_NAME;
                  end else if (phase_in == PH_NAME) begin
                     if (data_byte == CHAR_CR) begin
                        phase_in = PH_PENDING;
                        mode_in  = LX_BETWEEN;
                     end else begin
                        payload_start_in = nxt;
                        slot_b   = make_word(KIND_PAYLOAD, FIELD_WIDTH'(nxt), '0, line_in,
                                             ERR_NONE);
                        vb       = 1'b1;
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     slot_b   = make_word(KIND_ERROR, cur_field, '0, line_in,
                                          expect_error(phase_in));
                     vb       = 1'b1;
                     phase_in = PH_HALT;
                  end
               end
               CHAR_COLON: begin
                  if (phase_in == PH_COLON) begin
                     phase_in = PH_VALUE;
                  end else begin
                     slot_b   = make_word(KIND_ERROR, cur_field, '0, line_in,
                                          expect_error(phase_in));
                     vb       = 1'b1;
                     phase_in = PH_HALT;
                  end
               end
               CHAR_QUOTE: begin
                  mode_in        = LX_QUOTED;
                  token_start_in = nxt;
               end
               default: begin
                  mode_in        = LX_BARE;
                  token_start_in = cur;
               end
            endcase
         end
      end

      // end of message
      if (final_byte) begin
         if (phase_in != PH_HALT) begin
            vc = 1'b1;
            case (phase_in)
               PH_PAYLOAD: begin
                  slot_c = make_word(KIND_END, FIELD_WIDTH'(payload_start_in),
                                     FIELD_WIDTH'(nxt - payload_start_in), line_in, ERR_NONE);
               end
               PH_PENDING: begin
                  slot_c = make_word(KIND_PAYLOAD, FIELD_WIDTH'(nxt), '0, line_in, ERR_NONE);
                  slot_d = make_word(KIND_END, FIELD_WIDTH'(nxt), '0, line_in, ERR_NONE);
                  vd     = 1'b1;
               end
               default: begin
                  if ((mode_in == LX_BARE) || (mode_in == LX_QUOTED) ||
                      (phase_in != PH_NAME)) begin
                     slot_c = make_word(KIND_ERROR, cur_field, '0, line_in,
                                        expect_error(phase_in));
                  end else begin
                     slot_c = make_word(KIND_END, FIELD_WIDTH'(nxt), '0, line_in, ERR_NONE);
                  end
               end
            endcase
         end
         phase_in         = PH_METHOD;
         mode_in          = LX_BETWEEN;
         token_start_in   = '0;
         byte_pos_in      = '0;
         line_in          = FIELD_WIDTH'(1);
         payload_start_in = '0;
      end else if (byte_pos_ff != POS_MAX) begin
         byte_pos_in = nxt;
      end
   end

   // pack the first two words in order
   assign total_valid = 3'(va) + 3'(vb) + 3'(vc) + 3'(vd);

   always_comb begin
      words.word0 = va ? slot_a : (vb ? slot_b : (vc ? slot_c : slot_d));
      if (va) begin
         words.word1 = vb ? slot_b : (vc ? slot_c : slot_d);
      end else if (vb) begin
         words.word1 = vc ? slot_c : slot_d;
      end else begin
         words.word1 = slot_d;
      end
      if (!accept) begin
         words.count = 2'd0;
      end else if (total_valid >= 3'd2) begin
         words.count = 2'd2;
      end else begin
         words.count = total_valid[1:0];
      end
      words.word0.run_last = (total_valid == 3'd1);
      words.word1.run_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_METHOD;
         mode_ff          <= LX_BETWEEN;
         token_start_ff   <= '0;
         byte_pos_ff      <= '0;
         line_ff          <= FIELD_WIDTH'(1);
         payload_start_ff <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         mode_ff          <= mode_in;
         token_start_ff   <= token_start_in;
         byte_pos_ff      <= byte_pos_in;
         line_ff          <= line_in;
         payload_start_ff <= payload_start_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hrp_queue.sv =====
`default_nettype none

module hrp_queue #(
   parameter int unsigned DEPTH = hrp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hrp_pkg::front_out_type words,
   input  wire logic                  pop,
   output hrp_pkg::result_type        head,
   output logic                       empty,
   output logic                       full
);
   import hrp_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff > CNT_W'(DEPTH - 2));
   assign head    = entry_ff[rd_ptr_ff];
   assign pop_ok  = pop && !empty;
   assign wr_next = wr_ptr_ff + PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(words.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop_ok);
   assign count_in  = count_ff + CNT_W'(words.count) - CNT_W'(pop_ok);

   always_ff @(posedge clock) begin
      if (words.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= words.word0;
      end
      if (words.count == 2'd2) begin
         entry_ff[wr_next] <= words.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/http_request_header_parser_unit.sv =====
`default_nettype none

// channel   ports                                   handshake
// -------   -------------------------------------   ------------------------
// request   req_data_byte, req_final_byte          push high and full low
// response  rsp_token_kind .. rsp_run_last          pop high and empty low
//
// one byte per cycle while full is low; a byte makes zero, one or two response words
// a word can be popped the cycle after its byte is pushed
// the result queue holds QUEUE_DEPTH words; full rises when fewer than two slots are free,
// so input stalls then even while the response side is popping
// reset is synchronous; the first message starts at line 1, offset 0

module http_request_header_parser_unit #(
   parameter int unsigned POSITION_WIDTH = hrp_pkg::POSITION_WIDTH_DEFAULT,
   parameter int unsigned QUEUE_DEPTH    = hrp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            req_final_byte,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic [2:0]                           rsp_token_kind,
   output logic [hrp_pkg::FIELD_WIDTH-1:0]      rsp_field_offset,
   output logic [hrp_pkg::FIELD_WIDTH-1:0]      rsp_field_length,
   output logic [hrp_pkg::FIELD_WIDTH-1:0]      rsp_line_count,
   output logic [3:0]                           rsp_error_code,
   output logic                                 rsp_run_last
);
   import hrp_pkg::*;

   logic          accept;
   front_out_type front_words;
   result_type    head;

   assign accept = push && !full;

   hrp_front #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .words      (front_words)
   );

   hrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .words (front_words),
      .pop   (pop),
      .head  (head),
      .empty (empty),
      .full  (full)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_field_offset = head.offset;
   assign rsp_field_length = head.length;
   assign rsp_line_count   = head.line;
   assign rsp_error_code   = head.code;
   assign rsp_run_last     = head.run_last;

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue full while empty");

   a_word_arrives: assert property (@(posedge clock) disable iff (reset)
      (accept && (front_words.count != 2'd0)) |=> !empty)
      else $error("pushed word not visible");

   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_token_kind == KIND_ERROR)) |-> (rsp_error_code != ERR_NONE))
      else $error("error word without code");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import hrp_pkg::*;

   localparam int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT;
   localparam int unsigned POS_LAST       = (1 << POSITION_WIDTH) - 1;
   localparam int          CYCLE_LIMIT    = 2_000_000;
   localparam int          ITEM_COUNT     = 700;

   typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   push           = 1'b0;
   logic                   full;
   logic [7:0]             req_data_byte  = 8'h00;
   logic                   req_final_byte = 1'b0;
   logic                   empty;
   logic                   pop            = 1'b0;
   logic [2:0]             rsp_token_kind;
   logic [FIELD_WIDTH-1:0] rsp_field_offset;
   logic [FIELD_WIDTH-1:0] rsp_field_length;
   logic [FIELD_WIDTH-1:0] rsp_line_count;
   logic [3:0]             rsp_error_code;
   logic                   rsp_run_last;

   http_request_header_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_field_offset (rsp_field_offset),
      .rsp_field_length (rsp_field_length),
      .rsp_line_count   (rsp_line_count),
      .rsp_error_code   (rsp_error_code),
      .rsp_run_last     (rsp_run_last)
   );

   always #6 clock = ~clock;

   // parser state mirrored by the token predictor
   phase_type   ps_phase;
   lexer_type   ps_lexer;
   int unsigned ps_token_start;
   int unsigned ps_position;
   int unsigned ps_line;
   int unsigned ps_payload;
   int unsigned ps_cur;
   result_type  step_words[$];
   result_type  token_queue[$];

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          sent_bytes     = 0;
   int          burst_left     = 0;
   bit          tx_idles       = 1'b1;
   logic [7:0]  msg_bytes[$];

   rx_mode_type rx_mode    = RX_FREE;
   int          hold_asked = 0;
   int          hold_seen  = 0;
   int          hold_left  = 0;
   int          rx_age     = 0;
   logic [15:0] rx_pattern = 16'hC3A5;

   function automatic void restart_parser();
      ps_phase       = PH_METHOD;
      ps_lexer       = LX_BETWEEN;
      ps_token_start = 0;
      ps_position    = 0;
      ps_line        = 1;
      ps_payload     = 0;
   endfunction

   function automatic void add_word(kind_type kind, int unsigned offset, int unsigned length,
                                    error_type code);
      result_type w;
      if (step_words.size() >= 2) return;
      w.kind     = kind;
      w.offset   = offset[FIELD_WIDTH-1:0];
      w.length   = length[FIELD_WIDTH-1:0];
      w.line     = ps_line[FIELD_WIDTH-1:0];
      w.code     = code;
      w.run_last = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void raise_error(error_type code);
      add_word(KIND_ERROR, ps_cur, 0, code);
      ps_phase = PH_HALT;
   endfunction

   function automatic void raise_expected();
      case (ps_phase)
         PH_METHOD: raise_error(ERR_METHOD);
         PH_URI:    raise_error(ERR_URI);
         PH_PROTO:  raise_error(ERR_PROTOCOL);
         PH_NAME:   raise_error(ERR_NAME);
         PH_COLON:  raise_error(ERR_COLON);
         PH_VALUE:  raise_error(ERR_VALUE);
         default:   raise_error(ERR_EOL);
      endcase
   endfunction

   function automatic void take_string(int unsigned start, int unsigned length);
      case (ps_phase)
         PH_METHOD: begin
            add_word(KIND_METHOD, start, length, ERR_NONE);
            ps_phase = PH_URI;
         end
         PH_URI: begin
            add_word(KIND_URI, start, length, ERR_NONE);
            ps_phase = PH_PROTO;
         end
         PH_PROTO: begin
            add_word(KIND_PROTOCOL, start, length, ERR_NONE);
            ps_phase = PH_EOL1;
         end
         PH_NAME: begin
            add_word(KIND_NAME, start, length, ERR_NONE);
            ps_phase = PH_COLON;
         end
         PH_VALUE: begin
            add_word(KIND_VALUE, start, length, ERR_NONE);
            ps_phase = PH_EOL2;
         end
         default: raise_expected();
      endcase
   endfunction

   function automatic void take_line_end(bit by_cr);
      if (ps_phase == PH_EOL1 || ps_phase == PH_EOL2) begin
         if (ps_line < LINE_MAX) ps_line++;
         ps_phase = PH_NAME;
      end else if (ps_phase == PH_NAME) begin
         if (by_cr) begin
            // blank line ended by cr, payload start waits for the next byte
            ps_phase = PH_PENDING;
            ps_lexer = LX_BETWEEN;
         end else begin
            ps_payload = ps_cur + 1;
            add_word(KIND_PAYLOAD, ps_payload, 0, ERR_NONE);
            ps_phase = PH_PAYLOAD;
         end
      end else begin
         raise_expected();
      end
   endfunction

   function automatic void scan_between(logic [7:0] value);
      if (value == CHAR_SPACE) return;
      if (value == CHAR_CR) begin
         ps_lexer = LX_AFTER_CR;
         take_line_end(1'b1);
      end else if (value == CHAR_LF) begin
         take_line_end(1'b0);
      end else if (value == CHAR_COLON) begin
         if (ps_phase == PH_COLON) ps_phase = PH_VALUE;
         else raise_expected();
      end else if (value == CHAR_QUOTE) begin
         ps_lexer       = LX_QUOTED;
         ps_token_start = ps_cur + 1;
      end else begin
         ps_lexer       = LX_BARE;
         ps_token_start = ps_cur;
      end
   endfunction

   function automatic void lex_byte(logic [7:0] value);
      case (ps_lexer)
         LX_AFTER_CR: begin
            ps_lexer = LX_BETWEEN;
            if (value != CHAR_LF) scan_between(value);
         end
         LX_QUOTED: begin
            if (value == CHAR_QUOTE) begin
               ps_lexer = LX_BETWEEN;
               take_string(ps_token_start, ps_cur - ps_token_start);
            end
         end
         LX_BARE: begin
            if (value == CHAR_SPACE || value == CHAR_CR || value == CHAR_LF ||
                value == CHAR_COLON) begin
               ps_lexer = LX_BETWEEN;
               take_string(ps_token_start, ps_cur - ps_token_start);
               if (ps_phase != PH_HALT) scan_between(value);
            end
         end
         default: scan_between(value);
      endcase
   endfunction

   function automatic void finish_message();
      int unsigned total;
      total = ps_cur + 1;
      if (ps_phase == PH_PAYLOAD) begin
         add_word(KIND_END, ps_payload, total - ps_payload, ERR_NONE);
      end else if (ps_phase == PH_PENDING) begin
         ps_payload = total;
         add_word(KIND_PAYLOAD, ps_payload, 0, ERR_NONE);
         add_word(KIND_END, ps_payload, 0, ERR_NONE);
      end else if (ps_lexer == LX_BARE || ps_lexer == LX_QUOTED) begin
         raise_expected();
      end else if (ps_phase == PH_NAME) begin
         add_word(KIND_END, total, 0, ERR_NONE);
      end else begin
         raise_expected();
      end
   endfunction

   function automatic void parse_byte(logic [7:0] value, logic last_byte);
      result_type w;
      step_words.delete();
      ps_cur = ps_position;
      if (ps_phase != PH_HALT) begin
         if (ps_cur == POS_LAST) begin
            raise_error(ERR_OVERSIZE);
         end else if (ps_phase == PH_PENDING) begin
            ps_payload = (value == CHAR_LF) ? ps_cur + 1 : ps_cur;
            add_word(KIND_PAYLOAD, ps_payload, 0, ERR_NONE);
            ps_phase = PH_PAYLOAD;
            ps_lexer = LX_BETWEEN;
         end else if (ps_phase != PH_PAYLOAD) begin
            lex_byte(value);
         end
      end
      if (last_byte) begin
         if (ps_phase != PH_HALT) finish_message();
         restart_parser();
      end else if (ps_cur < POS_LAST) begin
         ps_position = ps_cur + 1;
      end
      foreach (step_words[i]) begin
         w          = step_words[i];
         w.run_last = (i == step_words.size() - 1);
         token_queue.push_back(w);
      end
   endfunction

   // result side
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         pop       <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         pop       <= 1'b0;
         hold_seen <= hold_asked;
         hold_left <= $urandom_range(200, 400);
      end else begin
         case (rx_mode)
            RX_FREE:   pop <= 1'b1;
            RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
            default: begin
               pop    <= rx_pattern[0];
               rx_age <= rx_age + 1;
               if (rx_age % 48 == 47) rx_pattern <= 16'($urandom) | 16'h0001;
               else rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
            end
         endcase
      end
   end

   function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_words
      result_type want;
      if (!reset && pop && !empty) begin
         if (token_queue.size() == 0) begin
            $display("%0t ns: word expected none, actual kind %0d offset %0d", $time,
                     rsp_token_kind, rsp_field_offset);
            mismatch_count++;
         end else begin
            want = token_queue.pop_front();
            check_field("token kind", 16'(want.kind), 16'(rsp_token_kind));
            check_field("field offset", want.offset, rsp_field_offset);
            check_field("field length", want.length, rsp_field_length);
            check_field("line count", want.line, rsp_line_count);
            check_field("error code", 16'(want.code), 16'(rsp_error_code));
            check_field("run last", 16'(want.run_last), 16'(rsp_run_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // request side
   task automatic send_byte(input logic [7:0] value, input logic last_byte);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = tx_idles ? $urandom_range(1, 8) : 0;
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push           <= 1'b1;
      req_data_byte  <= value;
      req_final_byte <= last_byte;
      do @(posedge clock); while (full);
      parse_byte(value, last_byte);
      sent_bytes++;
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++) begin
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      end
      msg_bytes.delete();
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void queue_text(string text);
      for (int i = 0; i < text.len(); i++) msg_bytes.push_back(text[i]);
   endfunction

   task automatic send_text(string text);
      queue_text(text);
      send_message();
   endtask

   function automatic logic [7:0] pick_any_char();
      case ($urandom_range(0, 9))
         0:       return CHAR_SPACE;
         1:       return CHAR_CR;
         2:       return CHAR_LF;
         3:       return CHAR_COLON;
         4:       return CHAR_QUOTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_spaces(int least);
      repeat ($urandom_range(least, least + 2)) msg_bytes.push_back(CHAR_SPACE);
   endfunction

   function automatic void add_token();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) begin
         msg_bytes.push_back(CHAR_QUOTE);
         repeat ($urandom_range(0, 5)) begin
            do c = pick_any_char(); while (c == CHAR_QUOTE);
            msg_bytes.push_back(c);
         end
         msg_bytes.push_back(CHAR_QUOTE);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_SPACE || c == CHAR_CR || c == CHAR_LF || c == CHAR_COLON ||
                   c == CHAR_QUOTE);
            msg_bytes.push_back(c);
         end
      end
   endfunction

   function automatic void add_line_end();
      case ($urandom_range(0, 2))
         0: begin
            msg_bytes.push_back(CHAR_CR);
            msg_bytes.push_back(CHAR_LF);
         end
         1:       msg_bytes.push_back(CHAR_LF);
         default: msg_bytes.push_back(CHAR_CR);
      endcase
   endfunction

   function automatic void build_random_message();
      int choice;
      int cut;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 12)) msg_bytes.push_back(pick_any_char());
         return;
      end
      add_spaces(0);
      add_token();
      add_spaces(1);
      add_token();
      add_spaces(1);
      add_token();
      add_spaces(0);
      add_line_end();
      repeat ($urandom_range(0, 4)) begin
         add_spaces(0);
         add_token();
         add_spaces(0);
         msg_bytes.push_back(CHAR_COLON);
         add_spaces(0);
         add_token();
         add_spaces(0);
         add_line_end();
      end
      choice = $urandom_range(0, 99);
      if (choice < 60) begin
         add_spaces(0);
         add_line_end();
         repeat ($urandom_range(0, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (choice >= 75 && choice < 88) begin
         cut = $urandom_range(1, msg_bytes.size());
         while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end else if (choice >= 88) begin
         repeat ($urandom_range(1, 2))
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = pick_any_char();
      end
   endfunction

   task automatic test_request_line();
      send_text("GET /a HTTP/1.1\015\nHost: example\015\n\015\nxy");
      send_text("\"PO ST\" \"/x:y\" \"\"\n\n");
      send_text("  M   U P  \n");
      send_text("A B C\nn:v\n");
   endtask

   task automatic test_line_ends();
      send_text("A B C\015k:v\015j:\"w\"\015\n\015ZZ");
      send_text("A B C\015\n\015\n");
      send_text("A B C\n\015");
      send_text("A B C\n\nP\015\nQ");
   endtask

   task automatic test_early_end();
      send_text("GET");
      send_text("\"GE");
      send_text("A B");
      send_text("A B C");
      send_text(" ");
      send_text("X");
      send_text("A B C\nn");
      send_text("A B C\nn:");
      send_text("A B C\nn:v");
      send_text("A B C\n\"n");
      send_text("A B \"C");
   endtask

   task automatic test_wrong_tokens();
      send_text(":abc\n");
      send_text("GET\nxx");
      send_text("A:");
      send_text("A B C D\n");
      send_text("A B C\nname value\n");
      send_text("A B C\nn:\n");
      send_text("A B C\n:v\n");
      send_text("A B C\nn::v\n");
      send_text("A B C\nn:v w\n");
      send_text("A B\015");
      send_text("\"A\"\"B\" C D\n");
   endtask

   // receiver holds off while header words pile up
   task automatic test_backpressure();
      tx_idles = 1'b0;
      rx_mode    <= RX_FREE;
      hold_asked <= hold_asked + 1;
      queue_text("A B C\n");
      repeat (8) queue_text("name:value\n");
      queue_text("\npayload");
      send_message();
   endtask

   task automatic test_random();
      while (sent_bytes < ITEM_COUNT) begin
         tx_idles = ($urandom_range(0, 3) != 0);
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         if ($urandom_range(0, 39) == 0) hold_asked <= hold_asked + 1;
         if ($urandom_range(0, 19) == 0) wait_drained();
         build_random_message();
         send_message();
      end
   endtask

   initial begin
      restart_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      rx_mode <= RX_RANDOM;
      test_request_line();
      wait_drained();
      rx_mode <= RX_PATTERN;
      test_line_ends();
      wait_drained();
      test_early_end();
      wait_drained();
      rx_mode <= RX_RANDOM;
      test_wrong_tokens();
      wait_drained();
      test_backpressure();
      wait_drained();
      test_random();
      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
